FILE: rtl/core/cylindrical_side_forward_map_core_defines.svh
// assertion macros used by the checker file
// no dependencies; expects clk and rst_n in the scope of use
`ifndef CYLINDRICAL_SIDE_FORWARD_MAP_CORE_DEFINES_SVH
`define CYLINDRICAL_SIDE_FORWARD_MAP_CORE_DEFINES_SVH

// property checked outside reset
`define CSFM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("csfm check failed");

// property checked at every edge, reset included
`define CSFM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("csfm check failed");

`endif

FILE: rtl/core/csfm_pkg.sv
// types, constants and arithmetic helpers of the cylindrical side forward map
// no dependencies
package csfm_pkg;

  localparam int CW = 21;
  localparam int FB = 14;
  localparam logic signed [CW-1:0] ONE_Q = 21'sd16384;
  localparam logic signed [CW-1:0] SAT_HI = 21'sd1048575;
  localparam logic signed [CW-1:0] SAT_LO = -21'sd1048576;

  // register indexes
  typedef enum logic [2:0] {
    REG_INNER_CENTER = 3'd0,
    REG_OUTER_CENTER = 3'd1,
    REG_INNER_RADIUS = 3'd2,
    REG_OUTER_RADIUS = 3'd3,
    REG_INNER_UPPER  = 3'd4,
    REG_INNER_LOWER  = 3'd5,
    REG_OUTER_UPPER  = 3'd6,
    REG_OUTER_LOWER  = 3'd7
  } reg_idx_t;

  // pipeline stage map
  localparam int ST_IN      = 0;
  localparam int ST_MUL     = 1;
  localparam int ST_HALF    = 2;
  localparam int ST_SQ      = 3;
  localparam int ST_RAD     = 4;
  localparam int RHO_SQ0    = 2;
  localparam int RHO_STEPS  = 21;
  localparam int CIRC_SQ0   = 5;
  localparam int CIRC_STEPS = 20;
  localparam int ST_RHO     = 25;
  localparam int ST_PROD    = 26;
  localparam int ST_SUM     = 27;
  localparam int ST_SCALE   = 28;
  localparam int ST_MAG     = 29;
  localparam int DIV0       = 30;
  localparam int DIV_STEPS  = 31;
  localparam int ST_OUT     = 61;
  localparam int NS         = 62;

  typedef struct packed {
    logic [43:0] rem;
    logic [21:0] root;
  } sq_t;

  typedef struct packed {
    logic [41:0] rem;
    logic [30:0] q;
  } dv_t;

  typedef struct packed {
    logic signed [CW-1:0] xb;
    logic signed [CW-1:0] yb;
    logic signed [CW-1:0] h;
    logic [40:0]          xx;
    logic [40:0]          yy;
    logic signed [42:0]   hd1;
    logic signed [42:0]   hd2;
    logic signed [CW-1:0] c1;
    logic signed [CW-1:0] c2;
    logic signed [CW-1:0] zl1;
    logic signed [CW-1:0] zl2;
    logic [40:0]          cc1;
    logic [40:0]          cc2;
    logic [39:0]          rr1;
    logic [39:0]          rr2;
    sq_t                  rsq;
    sq_t                  csq1;
    sq_t                  csq2;
    logic [19:0]          rho;
    logic                 rz;
    logic signed [21:0]   lo;
    logic signed [21:0]   hi;
    logic signed [42:0]   p1;
    logic signed [42:0]   p2;
    logic signed [42:0]   ax1;
    logic signed [42:0]   ax2;
    logic signed [42:0]   ay1;
    logic signed [42:0]   ay2;
    logic signed [42:0]   az1;
    logic signed [42:0]   az2;
    logic signed [CW-1:0] w;
    logic signed [29:0]   tx;
    logic signed [29:0]   ty;
    logic signed [CW-1:0] z;
    logic signed [41:0]   mx;
    logic signed [41:0]   my;
    logic                 negx;
    logic                 negy;
    logic                 ovx;
    logic                 ovy;
    dv_t                  dx;
    dv_t                  dy;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 err;
  } item_t;

  function automatic logic ovf21(input logic signed [47:0] v);
    return (v > 48'(SAT_HI)) || (v < 48'(SAT_LO));
  endfunction

  function automatic logic signed [CW-1:0] sat21(input logic signed [47:0] v);
    if (v > 48'(SAT_HI)) return SAT_HI;
    if (v < 48'(SAT_LO)) return SAT_LO;
    return v[CW-1:0];
  endfunction

  // one result bit of a floor square root, remainder form
  function automatic sq_t sqrt_step(input sq_t a, input int k);
    sq_t         r;
    logic [43:0] delta;
    r = a;
    delta = ({22'd0, a.root} << (k + 1)) + (44'd1 << (2 * k));
    if (a.rem >= delta) begin
      r.rem  = a.rem - delta;
      r.root = a.root | (22'd1 << k);
    end
    return r;
  endfunction

  // one quotient bit of a restoring divide
  function automatic dv_t div_step(input dv_t a, input logic [19:0] d, input int k);
    dv_t         r;
    logic [51:0] ds;
    r = a;
    ds = {32'd0, d} << k;
    if ({10'd0, a.rem} >= ds) begin
      r.rem = a.rem - ds[41:0];
      r.q   = a.q | (31'd1 << k);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/cylindrical_side_forward_map_core.sv
// cylindrical side forward map: source point to target point between two cut spheres
// depends on csfm_pkg
//
//   channel | ports                         | payload
//   input   | in_tvalid/in_tready/in_tdata  | src_x, src_y, src_z
//   result  | out_tvalid/out_tready/out_*   | dst_x, dst_y, dst_z, domain_error
//   config  | cfg_we/cfg_addr/cfg_wdata     | eight registers
//
// one point per cycle while the result is not stalled; the 31-step quotient pipeline and the
// 21-step square root stages set the depth
// rst_n synchronous, clears valid bits and the registers to their defaults
// each stage holds when the next one is full and stalled; bubbles close up
module cylindrical_side_forward_map_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // src_x, src_y, src_z, pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // dst_x, dst_y, dst_z, pad
  output logic [0:0]  out_tuser,  // domain_error
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [62:0] cfg_wdata
);
  import csfm_pkg::*;

  logic [62:0]          inner_c_r, outer_c_r;
  logic [19:0]          inner_rad_r, outer_rad_r;
  logic signed [CW-1:0] iu_r, il_r, ou_r, ol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_c_r   <= '0;
      outer_c_r   <= '0;
      inner_rad_r <= 20'd16384;
      outer_rad_r <= 20'd65536;
      iu_r        <= 21'sd8192;
      il_r        <= -21'sd8192;
      ou_r        <= 21'sd32768;
      ol_r        <= -21'sd32768;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_INNER_CENTER: inner_c_r   <= cfg_wdata;
        REG_OUTER_CENTER: outer_c_r   <= cfg_wdata;
        REG_INNER_RADIUS: inner_rad_r <= cfg_wdata[19:0];
        REG_OUTER_RADIUS: outer_rad_r <= cfg_wdata[19:0];
        REG_INNER_UPPER:  iu_r        <= cfg_wdata[CW-1:0];
        REG_INNER_LOWER:  il_r        <= cfg_wdata[CW-1:0];
        REG_OUTER_UPPER:  ou_r        <= cfg_wdata[CW-1:0];
        REG_OUTER_LOWER:  ol_r        <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  logic signed [CW-1:0] cx1, cy1, cz1, cx2, cy2, cz2;
  logic signed [21:0]   dz1, dz2;
  assign cx1 = inner_c_r[20:0];
  assign cy1 = inner_c_r[41:21];
  assign cz1 = inner_c_r[62:42];
  assign cx2 = outer_c_r[20:0];
  assign cy2 = outer_c_r[41:21];
  assign cz2 = outer_c_r[62:42];
  assign dz1 = 22'(iu_r) - 22'(il_r);
  assign dz2 = 22'(ou_r) - 22'(ol_r);

  item_t st_r [NS];
  item_t st_nxt [NS];
  logic  v_r [NS];
  logic  en [NS+1];

  assign en[NS] = out_tready;

  genvar gi;
  generate
    for (gi = 0; gi < NS; gi++) begin : g_stage
      localparam int I = gi;

      assign en[I] = !v_r[I] || en[I+1];

      always_comb begin
        item_t                src;
        logic signed [47:0]   t;
        logic signed [43:0]   s;
        logic [41:0]          m;
        logic signed [33:0]   qs;
        if (I == ST_IN) begin
          src = '0;
        end else begin
          src = st_r[(I == ST_IN) ? 0 : I-1];
        end
        st_nxt[I] = src;
        t  = '0;
        s  = '0;
        m  = '0;
        qs = '0;
        if (I == ST_IN) begin
          st_nxt[I].xb  = in_tdata[20:0];
          st_nxt[I].yb  = in_tdata[41:21];
          st_nxt[I].xx  = 41'(42'($signed(in_tdata[20:0])) * 42'($signed(in_tdata[20:0])));
          st_nxt[I].yy  = 41'(42'($signed(in_tdata[41:21])) * 42'($signed(in_tdata[41:21])));
          t             = 48'($signed(in_tdata[62:42])) + 48'(ONE_Q);
          st_nxt[I].h   = sat21(t);
          st_nxt[I].err = ovf21(t);
        end
        if (I == ST_MUL) begin
          st_nxt[I].rsq.rem  = 44'(src.xx) + 44'(src.yy);
          st_nxt[I].rsq.root = '0;
          st_nxt[I].hd1      = 43'(src.h) * 43'(dz1);
          st_nxt[I].hd2      = 43'(src.h) * 43'(dz2);
        end
        if (I == ST_HALF) begin
          t = 48'(il_r) - 48'(cz1) + 48'(src.hd1 >>> (FB + 1));
          st_nxt[I].c1 = sat21(t);
          st_nxt[I].err = src.err | ovf21(t);
          t = 48'(il_r) + 48'(src.hd1 >>> (FB + 1));
          st_nxt[I].zl1 = sat21(t);
          st_nxt[I].err = st_nxt[I].err | ovf21(t);
          t = 48'(ol_r) - 48'(cz2) + 48'(src.hd2 >>> (FB + 1));
          st_nxt[I].c2 = sat21(t);
          st_nxt[I].err = st_nxt[I].err | ovf21(t);
          t = 48'(ol_r) + 48'(src.hd2 >>> (FB + 1));
          st_nxt[I].zl2 = sat21(t);
          st_nxt[I].err = st_nxt[I].err | ovf21(t);
        end
        if (I == ST_SQ) begin
          st_nxt[I].cc1 = 41'(42'(src.c1) * 42'(src.c1));
          st_nxt[I].cc2 = 41'(42'(src.c2) * 42'(src.c2));
          st_nxt[I].rr1 = 40'(inner_rad_r) * 40'(inner_rad_r);
          st_nxt[I].rr2 = 40'(outer_rad_r) * 40'(outer_rad_r);
        end
        if (I == ST_RAD) begin
          st_nxt[I].csq1.root = '0;
          st_nxt[I].csq2.root = '0;
          if (src.cc1 > 41'(src.rr1)) begin
            st_nxt[I].csq1.rem = '0;
            st_nxt[I].err      = 1'b1;
          end else begin
            st_nxt[I].csq1.rem = 44'(41'(src.rr1) - src.cc1);
          end
          if (src.cc2 > 41'(src.rr2)) begin
            st_nxt[I].csq2.rem = '0;
            st_nxt[I].err      = 1'b1;
          end else begin
            st_nxt[I].csq2.rem = 44'(41'(src.rr2) - src.cc2);
          end
        end
        if (I >= RHO_SQ0 && I < RHO_SQ0 + RHO_STEPS) begin
          st_nxt[I].rsq = sqrt_step(src.rsq, RHO_SQ0 + RHO_STEPS - 1 - I);
        end
        if (I >= CIRC_SQ0 && I < CIRC_SQ0 + CIRC_STEPS) begin
          st_nxt[I].csq1 = sqrt_step(src.csq1, CIRC_SQ0 + CIRC_STEPS - 1 - I);
          st_nxt[I].csq2 = sqrt_step(src.csq2, CIRC_SQ0 + CIRC_STEPS - 1 - I);
        end
        if (I == ST_RHO) begin
          if (src.rsq.root > 22'd1048575) begin
            st_nxt[I].rho = 20'hFFFFF;
            st_nxt[I].err = 1'b1;
          end else begin
            st_nxt[I].rho = src.rsq.root[19:0];
          end
          st_nxt[I].rz = (src.rsq.root == '0);
          if (src.rsq.root == '0) begin
            st_nxt[I].err = 1'b1;
          end
          st_nxt[I].lo = $signed({2'b00, st_nxt[I].rho}) - 22'sd16384;
          st_nxt[I].hi = 22'sd32768 - $signed({2'b00, st_nxt[I].rho});
        end
        if (I == ST_PROD) begin
          st_nxt[I].p1  = 43'($signed({1'b0, src.csq1.root[19:0]})) * 43'(src.hi);
          st_nxt[I].p2  = 43'($signed({1'b0, src.csq2.root[19:0]})) * 43'(src.lo);
          st_nxt[I].ax1 = 43'(cx1) * 43'(src.hi);
          st_nxt[I].ax2 = 43'(cx2) * 43'(src.lo);
          st_nxt[I].ay1 = 43'(cy1) * 43'(src.hi);
          st_nxt[I].ay2 = 43'(cy2) * 43'(src.lo);
          st_nxt[I].az1 = 43'(src.zl1) * 43'(src.hi);
          st_nxt[I].az2 = 43'(src.zl2) * 43'(src.lo);
        end
        if (I == ST_SUM) begin
          s = 44'(src.p2) + 44'(src.p1);
          st_nxt[I].w = sat21(48'($signed(s[43:FB])));
          st_nxt[I].err = src.err | ovf21(48'($signed(s[43:FB])));
          s = 44'(src.ax2) + 44'(src.ax1);
          st_nxt[I].tx = s[43:FB];
          s = 44'(src.ay2) + 44'(src.ay1);
          st_nxt[I].ty = s[43:FB];
          s = 44'(src.az2) + 44'(src.az1);
          st_nxt[I].z = sat21(48'($signed(s[43:FB])));
          st_nxt[I].err = st_nxt[I].err | ovf21(48'($signed(s[43:FB])));
        end
        if (I == ST_SCALE) begin
          st_nxt[I].mx = 42'(src.w) * 42'(src.xb);
          st_nxt[I].my = 42'(src.w) * 42'(src.yb);
        end
        if (I == ST_MAG) begin
          st_nxt[I].negx = src.mx[41];
          m = src.mx[41] ? 42'(-src.mx) : 42'(src.mx);
          st_nxt[I].ovx  = ({10'd0, m} >= ({32'd0, src.rho} << DIV_STEPS));
          st_nxt[I].dx.rem = m;
          st_nxt[I].dx.q   = '0;
          st_nxt[I].negy = src.my[41];
          m = src.my[41] ? 42'(-src.my) : 42'(src.my);
          st_nxt[I].ovy  = ({10'd0, m} >= ({32'd0, src.rho} << DIV_STEPS));
          st_nxt[I].dy.rem = m;
          st_nxt[I].dy.q   = '0;
        end
        if (I >= DIV0 && I < DIV0 + DIV_STEPS) begin
          st_nxt[I].dx = div_step(src.dx, src.rho, DIV0 + DIV_STEPS - 1 - I);
          st_nxt[I].dy = div_step(src.dy, src.rho, DIV0 + DIV_STEPS - 1 - I);
        end
        if (I == ST_OUT) begin
          qs = src.ovx ? 34'sh080000000 : $signed({3'b000, src.dx.q});
          if (src.negx) qs = -qs;
          if (src.rz) qs = '0;
          t = 48'(qs) + 48'(src.tx);
          st_nxt[I].x = sat21(t);
          st_nxt[I].err = src.err | ovf21(t);
          qs = src.ovy ? 34'sh080000000 : $signed({3'b000, src.dy.q});
          if (src.negy) qs = -qs;
          if (src.rz) qs = '0;
          t = 48'(qs) + 48'(src.ty);
          st_nxt[I].y = sat21(t);
          st_nxt[I].err = st_nxt[I].err | ovf21(t);
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[I] <= 1'b0;
        end else if (en[I]) begin
          v_r[I] <= (I == ST_IN) ? in_tvalid : v_r[(I == ST_IN) ? 0 : I-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en[I]) begin
          st_r[I] <= st_nxt[I];
        end
      end
    end
  endgenerate

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NS-1];
  assign out_tdata  = {1'b0, st_r[NS-1].z, st_r[NS-1].y, st_r[NS-1].x};
  assign out_tuser  = st_r[NS-1].err;

endmodule

FILE: rtl/core/csfm_checker.sv
// port-level checks of the cylindrical side forward map, bound to the top level
// depends on cylindrical_side_forward_map_core_defines.svh
`include "cylindrical_side_forward_map_core_defines.svh"

module csfm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // pipeline empties on reset
  `CSFM_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid)
  // stalled result holds
  `CSFM_ASSERT(a_hold, out_tvalid && !out_tready |=> out_tvalid && $stable({out_tdata, out_tuser}))
  // input backs up only behind a stalled result
  `CSFM_ASSERT(a_back_pressure, !in_tready |-> out_tvalid && !out_tready)
  // a free sink always frees the input
  `CSFM_ASSERT(a_ready_flow, out_tready |-> in_tready)

endmodule

bind cylindrical_side_forward_map_core csfm_checker u_csfm_checker (.*);
